FILE: design/wmpm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard matcher package
// Shared sizes, command and result types, character folding and the
// star-closure helper used by the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wmpm_pkg;

  localparam int PATTERNS      = 8;
  localparam int PATTERN_CHARS = 32;

  localparam int SLOT_W  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int POS_W   = (PATTERN_CHARS > 1) ? $clog2(PATTERN_CHARS) : 1;
  localparam int LEN_W   = $clog2(PATTERN_CHARS + 1);
  localparam int VEC_W   = PATTERN_CHARS + 1;
  localparam int USE_W   = 4;
  localparam int FIRST_W = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = Q_PTR_W + 1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_PATTERNS_IN_USE = 1'b0;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  typedef enum logic [1:0] {
    ACT_CHAR = 2'd0,
    ACT_LEN  = 2'd1,
    ACT_TEXT = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_LEN  = 2'd1,
    CMD_TEXT = 2'd2
  } cmd_kind_t;

  // One stored pattern character, already classified and case folded.
  typedef struct packed {
    logic       star;
    logic       any;
    logic [7:0] ch;
  } pchar_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [POS_W-1:0]   idx;
    logic [LEN_W-1:0]   len;
    pchar_t             pch;
    logic               has_sym;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic               matched;
    logic [FIRST_W-1:0] first;
  } res_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] f;
    f = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      f = c + 8'h20;
    end
    return f;
  endfunction

  // Reached stars also reach every position up to the end of their run.
  // The add ripples a carry through each run of stars that holds a
  // reached position and drops it on the first non-star position.
  function automatic logic [VEC_W-1:0] star_closure(input logic [VEC_W-1:0] reach,
                                                    input logic [VEC_W-1:0] star);
    logic [VEC_W-1:0] run;
    run = (reach & star) + star;
    return reach | (run ^ star);
  endfunction

endpackage

FILE: design/wmpm_front.sv
// ----------------------------------------------------------------------------
// Wildcard matcher front end
// Accepts input beats, drops the ones with no effect and turns the rest
// into classified commands for the queue.
// ----------------------------------------------------------------------------
module wmpm_front (
  input  logic                 in_valid,
  input  logic [1:0]           in_action,
  input  logic [2:0]           in_pattern_slot,
  input  logic [5:0]           in_position,
  input  logic [7:0]           in_symbol,
  input  logic                 in_has_symbol,
  input  logic                 in_last,
  output logic                 in_stall,
  input  logic                 q_full,
  output logic                 q_push,
  output wmpm_pkg::cmd_t       q_cmd
);

  logic keep;
  logic slot_ok;
  logic pos_ok;

  assign slot_ok = int'(in_pattern_slot) < wmpm_pkg::PATTERNS;
  assign pos_ok  = int'(in_position) < wmpm_pkg::PATTERN_CHARS;

  always_comb begin
    q_cmd         = '0;
    keep          = 1'b0;
    q_cmd.slot    = wmpm_pkg::SLOT_W'(in_pattern_slot);
    q_cmd.idx     = in_position[wmpm_pkg::POS_W-1:0];
    // saturate lengths to the table width
    q_cmd.len     = (int'(in_position) > wmpm_pkg::PATTERN_CHARS) ?
                    wmpm_pkg::LEN_W'(wmpm_pkg::PATTERN_CHARS) :
                    wmpm_pkg::LEN_W'(in_position);
    q_cmd.pch.ch  = wmpm_pkg::fold_case(in_symbol);
    q_cmd.has_sym = in_has_symbol;
    q_cmd.last    = in_last;
    case (in_action)
      wmpm_pkg::ACT_CHAR: begin
        q_cmd.kind     = wmpm_pkg::CMD_CHAR;
        q_cmd.pch.star = (in_symbol == wmpm_pkg::STAR_CHAR);
        q_cmd.pch.any  = (in_symbol == wmpm_pkg::ANY_CHAR);
        keep           = slot_ok && pos_ok;
      end
      wmpm_pkg::ACT_LEN: begin
        q_cmd.kind = wmpm_pkg::CMD_LEN;
        keep       = slot_ok;
      end
      wmpm_pkg::ACT_TEXT: begin
        q_cmd.kind = wmpm_pkg::CMD_TEXT;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

FILE: design/wmpm_fifo.sv
// ----------------------------------------------------------------------------
// Wildcard matcher command queue
// Short FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module wmpm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wmpm_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output wmpm_pkg::cmd_t  head
);

  wmpm_pkg::cmd_t                  entry_q [wmpm_pkg::QUEUE_DEPTH];
  logic [wmpm_pkg::Q_PTR_W-1:0]    wr_ptr_r;
  logic [wmpm_pkg::Q_PTR_W-1:0]    rd_ptr_r;
  logic [wmpm_pkg::Q_CNT_W-1:0]    count_r;
  logic [wmpm_pkg::Q_CNT_W-1:0]    count_nxt;

  assign full       = (count_r == wmpm_pkg::Q_CNT_W'(wmpm_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_q[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_q[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/wmpm_back.sv
// ----------------------------------------------------------------------------
// Wildcard matcher back end
// Executes queued commands: pattern table writes, and a slot-by-slot pass
// over the position vectors for each text beat, with the result register.
// ----------------------------------------------------------------------------
module wmpm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  wmpm_pkg::cmd_t                head,
  output logic                          pop,
  input  logic [wmpm_pkg::USE_W-1:0]    used_cfg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wmpm_pkg::res_t                res
);

  typedef struct packed {
    logic [7:0] fc;
    logic       has_sym;
    logic       last;
    logic       fresh;
  } text_t;

  localparam int VW = wmpm_pkg::VEC_W;
  localparam int SW = wmpm_pkg::SLOT_W;

  // pattern table, one row per slot
  wmpm_pkg::pchar_t [wmpm_pkg::PATTERN_CHARS-1:0] pat_mem [wmpm_pkg::PATTERNS];
  wmpm_pkg::pchar_t [wmpm_pkg::PATTERN_CHARS-1:0] row_rd_r;

  logic [wmpm_pkg::LEN_W-1:0] len_r   [wmpm_pkg::PATTERNS];
  logic [VW-1:0]              reach_r [wmpm_pkg::PATTERNS];

  // issue sequencer
  logic          busy_r;
  logic [SW-1:0] cnt_r;
  text_t         txt_r;
  logic          in_text_r;
  logic          res_pend_r;
  logic          text_ok;
  logic          start;
  logic          wr_char;
  logic          wr_len;
  logic          iss_valid;
  logic [SW-1:0] iss_slot;
  text_t         iss_txt;

  // stage A: row read back, effective vector
  logic                       a_valid_r;
  logic [SW-1:0]              a_slot_r;
  text_t                      a_txt_r;
  logic [wmpm_pkg::LEN_W-1:0] a_len_r;
  logic [VW-1:0]              a_star;
  logic [VW-1:0]              a_match;
  logic [VW-1:0]              a_eff;

  // stage B: step and closure
  logic                       b_valid_r;
  logic [SW-1:0]              b_slot_r;
  text_t                      b_txt_r;
  logic [wmpm_pkg::LEN_W-1:0] b_len_r;
  logic [VW-1:0]              b_eff_r;
  logic [VW-1:0]              b_star_r;
  logic [VW-1:0]              b_match_r;
  logic [VW-1:0]              b_step;
  logic [VW-1:0]              b_vec;
  logic                       b_hit;
  logic                       b_prior;
  logic                       found_r;
  logic                       found_nxt;
  logic [SW-1:0]              first_r;
  logic [SW-1:0]              first_nxt;
  logic                       res_fire;

  logic                       out_valid_r;
  wmpm_pkg::res_t             res_r;

  // ---------------------------------------------------------------- issue
  // Hold a final beat until no result is in flight and the output frees up.
  assign text_ok = !head.last || (!res_pend_r && (!out_valid_r || !out_stall));
  assign start   = !busy_r && head_valid && (head.kind == wmpm_pkg::CMD_TEXT) && text_ok;
  assign wr_char = !busy_r && head_valid && (head.kind == wmpm_pkg::CMD_CHAR);
  assign wr_len  = !busy_r && head_valid && (head.kind == wmpm_pkg::CMD_LEN);
  assign pop     = start || wr_char || wr_len;

  assign iss_valid = start || busy_r;
  assign iss_slot  = busy_r ? cnt_r : '0;

  always_comb begin
    if (busy_r) begin
      iss_txt = txt_r;
    end else begin
      iss_txt.fc      = head.pch.ch;
      iss_txt.has_sym = head.has_sym;
      iss_txt.last    = head.last;
      iss_txt.fresh   = !in_text_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      cnt_r      <= '0;
      in_text_r  <= 1'b0;
      res_pend_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r    <= (wmpm_pkg::PATTERNS > 1);
        cnt_r     <= SW'(1);
        in_text_r <= !head.last;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SW'(wmpm_pkg::PATTERNS - 1)) begin
          busy_r <= 1'b0;
        end
      end
      if (start && head.last) begin
        res_pend_r <= 1'b1;
      end else if (res_fire) begin
        res_pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      txt_r <= iss_txt;
    end
  end

  // pattern table: element write, registered row read
  always_ff @(posedge clk) begin
    if (wr_char) begin
      pat_mem[head.slot][head.idx] <= head.pch;
    end
    if (iss_valid) begin
      row_rd_r <= pat_mem[iss_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < wmpm_pkg::PATTERNS; s++) begin
        len_r[s] <= '0;
      end
    end else if (wr_len) begin
      len_r[head.slot] <= head.len;
    end
  end

  // ---------------------------------------------------------------- stage A
  always_comb begin
    a_star  = '0;
    a_match = '0;
    for (int i = 0; i < wmpm_pkg::PATTERN_CHARS; i++) begin
      if (wmpm_pkg::LEN_W'(i) < a_len_r) begin
        a_star[i]  = row_rd_r[i].star;
        a_match[i] = row_rd_r[i].any ||
                     (!row_rd_r[i].star && (row_rd_r[i].ch == a_txt_r.fc));
      end
    end
    // a new text starts at position zero plus the stars behind it
    if (a_txt_r.fresh) begin
      a_eff = wmpm_pkg::star_closure(VW'(1), a_star);
    end else begin
      a_eff = reach_r[a_slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= iss_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_slot_r  <= iss_slot;
    a_txt_r   <= iss_txt;
    a_len_r   <= len_r[iss_slot];
    b_slot_r  <= a_slot_r;
    b_txt_r   <= a_txt_r;
    b_len_r   <= a_len_r;
    b_eff_r   <= a_eff;
    b_star_r  <= a_star;
    b_match_r <= a_match;
  end

  // ---------------------------------------------------------------- stage B
  assign b_step  = (b_eff_r & b_star_r) | ((b_eff_r & b_match_r) << 1);
  // an empty item inside a text leaves the vector as it stands
  assign b_vec   = b_txt_r.has_sym ? wmpm_pkg::star_closure(b_step, b_star_r) :
                   b_txt_r.last    ? wmpm_pkg::star_closure(b_eff_r, b_star_r) :
                   b_eff_r;
  assign b_hit   = b_vec[b_len_r] && (int'(b_slot_r) < int'(used_cfg));
  assign b_prior = (b_slot_r == '0) ? 1'b0 : found_r;

  assign found_nxt = b_prior || b_hit;
  assign first_nxt = (b_hit && !b_prior) ? b_slot_r :
                     ((b_slot_r == '0) ? '0 : first_r);
  assign res_fire  = b_valid_r && b_txt_r.last &&
                     (b_slot_r == SW'(wmpm_pkg::PATTERNS - 1));

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      reach_r[b_slot_r] <= b_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (b_valid_r && b_txt_r.last) begin
        found_r <= found_nxt;
        first_r <= first_nxt;
      end
      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      res_r.matched <= found_nxt;
      res_r.first   <= found_nxt ? wmpm_pkg::FIRST_W'(first_nxt) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

`ifndef ASSERT_OFF
  a_res_lands_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> !out_valid_r)
    else $error("result overwrote a pending output beat");

  a_res_expected: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> res_pend_r)
    else $error("result produced with no final beat in flight");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !pop)
    else $error("command popped during a slot pass");

  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.matched) |-> (res_r.first == '0))
    else $error("first slot nonzero without a match");
`endif

endmodule

FILE: design/wildcard_multi_pattern_matcher.sv
// ----------------------------------------------------------------------------
// Wildcard multi-pattern matcher
// Case-insensitive glob matching of a streamed text against a table of
// patterns, reporting any match and the lowest matching slot.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each beat is a pattern character
//   write, a pattern length write or a text byte / text end. A text beat with
//   in_last set ends a text and yields exactly one output beat.
//   Output channel (out_valid / out_stall): out_matched and
//   out_first_match_res; the slot reads 0 when nothing matched.
//   Config port (APB style, pready tied high): patterns_in_use at byte
//   address 0; write it only while the block is idle.
// Timing:
//   The back end performs table writes as they reach the queue head. A text
//   beat runs one issue per pattern slot, set by the single read port of the
//   pattern table that feeds one slot row per cycle. The result of a final
//   beat follows its slot issues through 2 stages, A and B, to the output register.
//   Beats are taken into a 4-entry queue while earlier work proceeds.
// Reset: clears lengths, config, queue and all control; pattern characters
//   stay undefined until written and need no clearing pass.
// Stall: a stalled result holds in the output register; the next final beat
//   waits in the queue until that register frees up.
// ----------------------------------------------------------------------------
module wildcard_multi_pattern_matcher (
  input  logic                              clk,
  input  logic                              rst_n,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wmpm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wmpm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wmpm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [2:0]                        in_pattern_slot,
  input  logic [5:0]                        in_position,
  input  logic [7:0]                        in_symbol,
  input  logic                              in_has_symbol,
  input  logic                              in_last,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_matched,
  output logic [2:0]                        out_first_match_res
);

  logic [wmpm_pkg::USE_W-1:0] patterns_in_use_r;
  logic                       cfg_wr;
  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_head_valid;
  wmpm_pkg::cmd_t             q_cmd;
  wmpm_pkg::cmd_t             q_head;
  wmpm_pkg::res_t             res;

  // Config: one register; the byte offset bits do not select anything.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[wmpm_pkg::CFG_ADDR_W-1] == wmpm_pkg::REG_PATTERNS_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patterns_in_use_r <= '0;
    end else if (cfg_wr) begin
      patterns_in_use_r <= pwdata[wmpm_pkg::USE_W-1:0];
    end
  end

  assign prdata = (paddr[wmpm_pkg::CFG_ADDR_W-1] == wmpm_pkg::REG_PATTERNS_IN_USE) ?
                  wmpm_pkg::CFG_DATA_W'(patterns_in_use_r) : '0;

  // Classify beats and drop the ones with no effect.
  wmpm_front u_front (
    .in_valid        (in_valid),
    .in_action       (in_action),
    .in_pattern_slot (in_pattern_slot),
    .in_position     (in_position),
    .in_symbol       (in_symbol),
    .in_has_symbol   (in_has_symbol),
    .in_last         (in_last),
    .in_stall        (in_stall),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  // Decouple the front from the slot passes of the back end.
  wmpm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Run table writes and per-slot vector updates; hold the result beat.
  wmpm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .used_cfg   (patterns_in_use_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign out_matched         = res.matched;
  assign out_first_match_res = res.first;

endmodule

FILE: tb/wildcard_multi_pattern_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wildcard multi-pattern matcher testbench
// Loads wildcard patterns into the table, streams texts, and checks every
// match verdict against a cycle-free software copy of the matcher kept in a
// small scoreboard. Random gaps and stalls on both channels, one long hold
// on the result side, and several pattern-count settings including extremes.
// ----------------------------------------------------------------------------
module wildcard_multi_pattern_matcher_tb;
  import wmpm_pkg::*;

  // Action code with no meaning in the block; it must be dropped silently.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] IN_USE_ADDR =
    CFG_ADDR_W'(4 * int'(REG_PATTERNS_IN_USE));

  localparam int SETTLE_CYCLES = 40;    // margin for the back end to go quiet after the last verdict
  localparam int IDLE_LIMIT    = 4000;  // cycles with no beat moving anywhere
  localparam int HOLD_CYCLES   = 400;   // long result-side hold-off
  localparam int PHASE_BEATS   = 130;
  localparam int PHASES        = 6;
  localparam int TEXT_CAP      = 40;

  // --------------------------------------------------------------------------
  // Verdict scoreboard: keeps its own copy of the pattern table and of the
  // per-slot reach vectors, and queues the verdict each final text beat owes.
  // --------------------------------------------------------------------------
  class match_tracker;
    logic [7:0]       pat_mem [PATTERNS][PATTERN_CHARS];
    logic [LEN_W-1:0] pat_len [PATTERNS];
    logic [VEC_W-1:0] reach   [PATTERNS];
    logic             text_open;
    logic [USE_W-1:0] in_use;
    res_t             verdicts_due [$];
    int               errors;

    function new();
      foreach (pat_mem[s, i]) pat_mem[s][i] = 8'h00;
      foreach (pat_len[s]) begin
        pat_len[s] = '0;
        reach[s]   = '0;
      end
      text_open = 1'b0;
      in_use    = '0;
      errors    = 0;
    endfunction

    function logic [7:0] lower_ascii(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // A reached star also reaches the position right after it.
    function void close_stars(input int s);
      for (int i = 0; i < int'(pat_len[s]); i++) begin
        if (reach[s][i] && pat_mem[s][i] == STAR_CHAR) reach[s][i+1] = 1'b1;
      end
    endfunction

    function void advance(input logic [7:0] c);
      logic [VEC_W-1:0] nxt;
      logic [7:0]       fc;
      logic [7:0]       p;
      fc = lower_ascii(c);
      for (int s = 0; s < PATTERNS; s++) begin
        nxt = '0;
        for (int i = 0; i < int'(pat_len[s]); i++) begin
          if (reach[s][i]) begin
            p = pat_mem[s][i];
            if (p == STAR_CHAR) nxt[i] = 1'b1;
            else if (p == ANY_CHAR || lower_ascii(p) == fc) nxt[i+1] = 1'b1;
          end
        end
        reach[s] = nxt;
        close_stars(s);
      end
    endfunction

    function void set_in_use(input logic [USE_W-1:0] v);
      in_use = v;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function void take_beat(input logic [1:0] act, input logic [2:0] slot,
                            input logic [5:0] pos, input logic [7:0] sym,
                            input logic has, input logic last);
      int   used;
      logic found;
      int   first;
      res_t v;
      case (act)
        ACT_CHAR: begin
          if (slot < PATTERNS && pos < PATTERN_CHARS) pat_mem[slot][pos] = sym;
        end
        ACT_LEN: begin
          if (slot < PATTERNS) begin
            pat_len[slot] = (pos > PATTERN_CHARS) ? LEN_W'(PATTERN_CHARS) : LEN_W'(pos);
          end
        end
        ACT_TEXT: begin
          // The first text beat seeds every slot at position zero.
          if (!text_open) begin
            for (int s = 0; s < PATTERNS; s++) begin
              reach[s] = VEC_W'(1);
              close_stars(s);
            end
            text_open = 1'b1;
          end
          if (has) advance(sym);
          if (last) begin
            used  = (in_use > PATTERNS) ? PATTERNS : int'(in_use);
            found = 1'b0;
            first = 0;
            for (int s = 0; s < used; s++) begin
              close_stars(s);
              if (reach[s][pat_len[s]] && !found) begin
                found = 1'b1;
                first = s;
              end
            end
            foreach (reach[s]) reach[s] = '0;
            text_open = 1'b0;
            v.matched = found;
            v.first   = FIRST_W'(first);
            verdicts_due.push_back(v);
          end
        end
        default: ;  // unused action: no effect, no verdict
      endcase
    endfunction

    function void check_verdict(input logic m, input logic [FIRST_W-1:0] f);
      res_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result beat, actual matched %0d first %0d", $time, m, f);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (m !== want.matched) begin
        $display("%0t: matched mismatch, expected %0d actual %0d", $time, want.matched, m);
        errors++;
      end
      if (f !== want.first) begin
        $display("%0t: first_match_res mismatch, expected %0d actual %0d",
                 $time, want.first, f);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; everything starts at a known value.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic       in_valid        = 1'b0;
  logic       in_stall;
  logic [1:0] in_action       = '0;
  logic [2:0] in_pattern_slot = '0;
  logic [5:0] in_position     = '0;
  logic [7:0] in_symbol       = '0;
  logic       in_has_symbol   = 1'b0;
  logic       in_last         = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_matched;
  logic [2:0] out_first_match_res;

  always #5 clk = ~clk;

  wildcard_multi_pattern_matcher dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_pattern_slot     (in_pattern_slot),
    .in_position         (in_position),
    .in_symbol           (in_symbol),
    .in_has_symbol       (in_has_symbol),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_matched         (out_matched),
    .out_first_match_res (out_first_match_res)
  );

  match_tracker sb = new();

  // Stimulus side bookkeeping: which characters have been written, so that
  // no length ever covers a character the table never received.
  logic [PATTERN_CHARS-1:0] gen_written [PATTERNS];
  logic [7:0]               gen_pat     [PATTERNS][PATTERN_CHARS];
  int                       gen_len     [PATTERNS];
  logic [7:0]               text_bytes  [$];

  int beats_sent  = 0;
  int idle_cycles = 0;
  bit gaps_on     = 1'b0;
  bit stalls_on   = 1'b0;
  bit hold_req    = 1'b0;

  // --------------------------------------------------------------------------
  // Monitor and watchdog. Sampled at the edge, so values are the pre-edge ones
  // the block itself sees.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        sb.take_beat(in_action, in_pattern_slot, in_position, in_symbol,
                     in_has_symbol, in_last);
        moved = 1'b1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        sb.check_verdict(out_matched, out_first_match_res);
        moved = 1'b1;
      end
      if (psel && penable && pwrite && pready === 1'b1) begin
        if (paddr == IN_USE_ADDR) sb.set_in_use(pwdata[USE_W-1:0]);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result-side stall. Each pass assigns out_stall once and then advances at
  // least one edge. A hold request blocks the output for a long stretch while
  // the sender keeps pushing, so the queue fills and in_stall must rise.
  // --------------------------------------------------------------------------
  initial begin : result_stall
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        if ($urandom_range(0, 19) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Mostly short sender gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int written_prefix(input int s);
    int n;
    n = 0;
    while (n < PATTERN_CHARS && gen_written[s][n]) n++;
    return n;
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 1) c = c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pick_pat_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return STAR_CHAR;
    if (r < 40) return ANY_CHAR;
    if (r < 85) return pick_letter();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_text_byte();
    if ($urandom_range(0, 4) != 0) return pick_letter();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ($urandom_range(0, 1) == 0) return c;
    if (c >= 8'h61 && c <= 8'h7A) return c - 8'h20;
    if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  function automatic int pick_pat_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 16);
    return $urandom_range(17, PATTERN_CHARS);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. Every task is entered at a rising-edge time step and returns at
  // one; each beat is held until the edge at which in_stall is low.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [1:0] act, input logic [2:0] slot,
                           input logic [5:0] pos, input logic [7:0] sym,
                           input logic has, input logic last);
    int gap;
    in_valid        <= 1'b1;
    in_action       <= act;
    in_pattern_slot <= slot;
    in_position     <= pos;
    in_symbol       <= sym;
    in_has_symbol   <= has;
    in_last         <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic cfg_write(input logic [USE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= IN_USE_ADDR;
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid, wait out every owed verdict, then let the back end go quiet.
  // The first edge lets the monitor record the beat accepted just before.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Non-text beats carry random has_symbol / last bits; the block ignores them.
  task automatic write_char(input int s, input int pos, input logic [7:0] c);
    send_beat(ACT_CHAR, 3'(s), 6'(pos), c, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    if (pos < PATTERN_CHARS) begin
      gen_written[s][pos] = 1'b1;
      gen_pat[s][pos]     = c;
    end
  endtask

  // Clip the length to the written prefix; a full slot may get an oversized
  // length, which must saturate.
  task automatic set_len(input int s, input int want, input bit oversize);
    int pos;
    int prefix;
    prefix = written_prefix(s);
    pos = (want > prefix) ? prefix : want;
    if (pos == PATTERN_CHARS && (oversize || $urandom_range(0, 1) == 1)) begin
      pos = $urandom_range(PATTERN_CHARS + 1, 63);
    end
    send_beat(ACT_LEN, 3'(s), 6'(pos), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    gen_len[s] = (pos > PATTERN_CHARS) ? PATTERN_CHARS : pos;
  endtask

  task automatic load_pattern(input int s, input int len, input bit oversize);
    for (int i = 0; i < len; i++) write_char(s, i, pick_pat_char());
    set_len(s, len, oversize);
  endtask

  // Empty item: opens the text, moves no byte.
  task automatic send_empty_item();
    send_beat(ACT_TEXT, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
              8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  task automatic send_text();
    int   n;
    logic split_end;
    n = text_bytes.size();
    if ($urandom_range(0, 9) == 0) send_empty_item();
    if (n == 0) begin
      send_beat(ACT_TEXT, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    split_end = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 14) == 0) begin
        send_empty_item();
      end else if ($urandom_range(0, 24) == 0) begin
        // Rewrite the table in the middle of a text.
        if ($urandom_range(0, 1) == 0) begin
          write_char($urandom_range(0, PATTERNS - 1), $urandom_range(0, PATTERN_CHARS - 1),
                     pick_pat_char());
        end else begin
          set_len($urandom_range(0, PATTERNS - 1), $urandom_range(0, PATTERN_CHARS), 1'b0);
        end
      end
      send_beat(ACT_TEXT, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                text_bytes[i], 1'b1, (i == n - 1) && !split_end);
    end
    if (split_end) begin
      send_beat(ACT_TEXT, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // Expand a stored pattern into a text that should match it, then sometimes
  // spoil one byte so near misses show up too.
  task automatic derive_text(input int s);
    logic [7:0] c;
    text_bytes.delete();
    for (int i = 0; i < gen_len[s]; i++) begin
      c = gen_pat[s][i];
      if (c == STAR_CHAR) repeat ($urandom_range(0, 3)) text_bytes.push_back(pick_text_byte());
      else if (c == ANY_CHAR) text_bytes.push_back(8'($urandom_range(0, 255)));
      else text_bytes.push_back(flip_case(c));
    end
    if (text_bytes.size() > 0 && $urandom_range(0, 4) == 0) begin
      text_bytes[$urandom_range(0, text_bytes.size() - 1)] = pick_text_byte();
    end
    while (text_bytes.size() > TEXT_CAP) void'(text_bytes.pop_back());
  endtask

  task automatic random_text();
    int r;
    int n;
    text_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 10) n = 0;
    else if (r < 80) n = $urandom_range(1, 8);
    else n = $urandom_range(9, 30);
    repeat (n) text_bytes.push_back(pick_text_byte());
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      if ($urandom_range(0, 1) == 0) derive_text($urandom_range(0, PATTERNS - 1));
      else random_text();
      send_text();
    end else if (r < 65) begin
      load_pattern($urandom_range(0, PATTERNS - 1), pick_pat_len(), 1'b0);
    end else if (r < 75) begin
      // Noise the block must drop: unused action, or a character index
      // past the end of the slot.
      if ($urandom_range(0, 1) == 0) begin
        send_beat(ACT_UNUSED, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        write_char($urandom_range(0, PATTERNS - 1), $urandom_range(PATTERN_CHARS, 63),
                   8'($urandom_range(0, 255)));
      end
    end else if (r < 88) begin
      write_char($urandom_range(0, PATTERNS - 1), $urandom_range(0, PATTERN_CHARS - 1),
                 pick_pat_char());
    end else begin
      set_len($urandom_range(0, PATTERNS - 1), $urandom_range(0, PATTERN_CHARS), 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    logic [USE_W-1:0] plan_use [PHASES];
    int               start;
    bit               hold_done;

    foreach (gen_written[s]) begin
      gen_written[s] = '0;
      gen_len[s]     = 0;
    end
    plan_use[0] = 4'd8;
    plan_use[1] = 4'd15;
    plan_use[2] = 4'd1;
    plan_use[3] = 4'd0;
    plan_use[4] = 4'd4;
    plan_use[5] = 4'($urandom_range(0, 15));
    hold_done   = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling. With no pattern in use nothing can match.
    cfg_write(4'd0);
    send_beat(ACT_TEXT, 3'd0, 6'd0, 8'h00, 1'b0, 1'b1);
    settle();
    cfg_write(4'd8);

    // Every slot still has length zero: the empty text hits slot zero.
    send_beat(ACT_TEXT, 3'd7, 6'd63, 8'hFF, 1'b0, 1'b1);

    // Slot 0 "A*?", slot 1 "<zero byte>*", slot 2 "**".
    write_char(0, 0, 8'h41);
    write_char(0, 1, STAR_CHAR);
    write_char(0, 2, ANY_CHAR);
    set_len(0, 3, 1'b0);
    write_char(1, 0, 8'h00);
    write_char(1, 1, STAR_CHAR);
    set_len(1, 2, 1'b0);
    write_char(2, 0, STAR_CHAR);
    write_char(2, 1, STAR_CHAR);
    set_len(2, 2, 1'b0);

    // Case folding against slot 0.
    send_beat(ACT_TEXT, 3'd0, 6'd0, 8'h61, 1'b1, 1'b0);
    send_beat(ACT_TEXT, 3'd0, 6'd0, 8'h42, 1'b1, 1'b1);

    // Unused action and an out-of-range character index: both dropped.
    send_beat(ACT_UNUSED, 3'd5, 6'd33, 8'h2A, 1'b1, 1'b1);
    write_char(5, 45, 8'h7A);

    // Zero byte in the text, wrapped in empty items: slot 1 wins.
    send_beat(ACT_TEXT, 3'd0, 6'd0, 8'h00, 1'b0, 1'b0);
    send_beat(ACT_TEXT, 3'd0, 6'd0, 8'h00, 1'b1, 1'b0);
    send_beat(ACT_TEXT, 3'd0, 6'd0, 8'h11, 1'b0, 1'b0);
    send_beat(ACT_TEXT, 3'd0, 6'd0, 8'h78, 1'b1, 1'b1);

    // Empty text: the all-star slot 2 is the lowest match; empty slots 3 to 7 match too.
    send_beat(ACT_TEXT, 3'd3, 6'd1, 8'h80, 1'b0, 1'b1);

    // One byte, then a separate end beat.
    send_beat(ACT_TEXT, 3'd0, 6'd0, 8'h7A, 1'b1, 1'b0);
    send_beat(ACT_TEXT, 3'd0, 6'd0, 8'h5A, 1'b0, 1'b1);
    settle();

    // Random phases, each with its own pattern count. Phase 0 runs flat out.
    for (int ph = 0; ph < PHASES; ph++) begin
      gaps_on   = (ph != 0);
      stalls_on = (ph != 0);
      cfg_write(plan_use[ph]);
      // Fill one slot completely and give it an oversized length.
      load_pattern($urandom_range(0, PATTERNS - 1), PATTERN_CHARS, 1'b1);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        if (ph == 2 && !hold_done && beats_sent - start > 30) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        random_step();
      end
      // Sender pauses here until every verdict has come back.
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
